// ----- design/dps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types for the dynamic priority scheduler: queue entry layout,
// controller states, and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 16;
    localparam int TIME_W = 16;

    // one ready-queue entry
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        need;
        logic [TIME_W-1:0]        used;
    } entry_t;

    // read address source for the queue memory
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_NEXT
    } rd_sel_t;

    // which kind of result gets loaded into the output register
    typedef enum logic [1:0] {
        RES_ADD,
        RES_EMPTY_TICK,
        RES_TICK
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_INS,
        ST_CMP,
        ST_PUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      res_load;
        res_kind_t res_kind;
        logic      cand_from_in;
        logic      cand_from_head;
        logic      pop;
        logic      set_k;
        logic      dec_k;
        logic      wr_shift;
        logic      wr_cand;
        logic      inc_count;
    } dps_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic count_zero;
        logic full;
        logic need_zero;
        logic head_done;
        logic lower;
        logic k_one;
    } dps_status_t;

endpackage : dps_pkg
`default_nettype wire

// ----- design/dps_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dps_ctrl
// Controller for the scheduler: request handshake, output valid, and the
// sequencing of head pop and the sorted insertion walk.
// ----------------------------------------------------------------------------
module dps_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire dps_pkg::dps_status_t status,
    output dps_pkg::dps_cmd_t        cmd
);
    import dps_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output valid: set on a loaded result, cleared when taken
    always_comb begin
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && out_free) begin
                    if (!s_mode) begin
                        if (!(status.full || status.need_zero)) begin
                            state_next = ST_INS;
                        end
                    end else if (!status.count_zero) begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    state_next = status.head_done ? ST_IDLE : ST_INS;
                end
            end
            ST_INS: begin
                state_next = status.count_zero ? ST_PUT : ST_CMP;
            end
            ST_CMP: begin
                if (status.lower) begin
                    if (status.k_one) begin
                        state_next = ST_PUT;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUT: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (!s_mode) begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_ADD;
                        cmd.cand_from_in = !(status.full || status.need_zero);
                    end else if (status.count_zero) begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RES_EMPTY_TICK;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    cmd.res_load       = 1'b1;
                    cmd.res_kind       = RES_TICK;
                    cmd.pop            = 1'b1;
                    cmd.cand_from_head = !status.head_done;
                end
            end
            ST_INS: begin
                cmd.set_k = 1'b1;
                if (!status.count_zero) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_TAIL;
                end
            end
            ST_CMP: begin
                if (status.lower) begin
                    cmd.wr_shift = 1'b1;
                    cmd.dec_k    = 1'b1;
                    if (!status.k_one) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                    end
                end else begin
                    cmd.wr_cand   = 1'b1;
                    cmd.inc_count = 1'b1;
                end
            end
            ST_PUT: begin
                cmd.wr_cand   = 1'b1;
                cmd.inc_count = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule : dps_ctrl
`default_nettype wire

// ----- design/dps_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dps_datapath
// Ready queue held as a circular buffer in one memory, plus the candidate
// entry, walk pointer and result register. Insertion walks from the tail
// toward the head, moving lower-priority entries back one slot.
// ----------------------------------------------------------------------------
module dps_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dps_pkg::dps_cmd_t           cmd,
    output dps_pkg::dps_status_t             status,
    input  wire logic [dps_pkg::ID_W-1:0]    s_proc_id,
    input  wire logic signed [dps_pkg::PRIO_W-1:0] s_priority_req,
    input  wire logic [dps_pkg::TIME_W-1:0]  s_need_time,
    output logic                             m_ran_valid,
    output logic [dps_pkg::ID_W-1:0]         m_ran_id,
    output logic signed [dps_pkg::PRIO_W-1:0] m_ran_priority,
    output logic [dps_pkg::TIME_W-1:0]       m_ran_used,
    output logic                             m_finished,
    output logic                             m_add_rejected,
    output logic                             m_queue_empty
);
    import dps_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;
    entry_t cand_reg, cand_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [CNT_W-1:0] rd_logical;
    logic             wr_en;
    entry_t           wr_data;
    logic [TIME_W-1:0] head_used_inc;
    logic             full;

    logic             ran_valid_reg, finished_reg, rejected_reg, empty_reg;
    logic [ID_W-1:0]  ran_id_reg;
    logic signed [PRIO_W-1:0] ran_prio_reg;
    logic [TIME_W-1:0] ran_used_reg;

    // logical queue position to memory slot, modulo the depth
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] head,
        input logic [CNT_W-1:0] pos
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign full          = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_used_inc = rd_data_reg.used + TIME_W'(1);

    // status
    always_comb begin
        status.count_zero = (count_reg == '0);
        status.full       = full;
        status.need_zero  = (s_need_time == '0);
        status.head_done  = (head_used_inc == rd_data_reg.need);
        status.lower      = (rd_data_reg.prio < cand_reg.prio);
        status.k_one      = (k_reg == CNT_W'(1));
    end

    // read address select
    always_comb begin
        case (cmd.rd_sel)
            RD_HEAD: rd_logical = '0;
            RD_TAIL: rd_logical = count_reg - CNT_W'(1);
            RD_NEXT: rd_logical = k_reg - CNT_W'(2);
            default: rd_logical = '0;
        endcase
    end

    assign rd_addr = slot_of(head_reg, rd_logical);
    assign wr_addr = slot_of(head_reg, k_reg);
    assign wr_en   = cmd.wr_shift || cmd.wr_cand;
    assign wr_data = cmd.wr_shift ? rd_data_reg : cand_reg;

    // queue memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // head, count and walk pointer updates
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.pop) begin
            head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.inc_count) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.set_k) begin
            k_next = count_reg;
        end else if (cmd.dec_k) begin
            k_next = k_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    // candidate entry to insert
    always_comb begin
        cand_next = cand_reg;
        if (cmd.cand_from_in) begin
            cand_next.id   = s_proc_id;
            cand_next.prio = s_priority_req;
            cand_next.need = s_need_time;
            cand_next.used = '0;
        end else if (cmd.cand_from_head) begin
            cand_next.id   = rd_data_reg.id;
            cand_next.prio = (rd_data_reg.prio == PRIO_MIN) ? rd_data_reg.prio
                                                             : rd_data_reg.prio - PRIO_W'(1);
            cand_next.need = rd_data_reg.need;
            cand_next.used = head_used_inc;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            case (cmd.res_kind)
                RES_ADD: begin
                    ran_valid_reg <= 1'b0;
                    ran_id_reg    <= '0;
                    ran_prio_reg  <= '0;
                    ran_used_reg  <= '0;
                    finished_reg  <= 1'b0;
                    rejected_reg  <= full || status.need_zero;
                    empty_reg     <= (full || status.need_zero) && status.count_zero;
                end
                RES_TICK: begin
                    ran_valid_reg <= 1'b1;
                    ran_id_reg    <= rd_data_reg.id;
                    ran_prio_reg  <= rd_data_reg.prio;
                    ran_used_reg  <= head_used_inc;
                    finished_reg  <= status.head_done;
                    rejected_reg  <= 1'b0;
                    empty_reg     <= status.head_done && (count_reg == CNT_W'(1));
                end
                default: begin
                    ran_valid_reg <= 1'b0;
                    ran_id_reg    <= '0;
                    ran_prio_reg  <= '0;
                    ran_used_reg  <= '0;
                    finished_reg  <= 1'b0;
                    rejected_reg  <= 1'b0;
                    empty_reg     <= 1'b1;
                end
            endcase
        end
    end

    assign m_ran_valid    = ran_valid_reg;
    assign m_ran_id       = ran_id_reg;
    assign m_ran_priority = ran_prio_reg;
    assign m_ran_used     = ran_used_reg;
    assign m_finished     = finished_reg;
    assign m_add_rejected = rejected_reg;
    assign m_queue_empty  = empty_reg;

endmodule : dps_datapath
`default_nettype wire

// ----- design/dynamic_priority_scheduler.sv -----
`default_nettype none
// Results: a rejected or accepted add and a tick on an empty queue load the result register
// as the request is accepted; a tick first reads the head entry, then loads the result register.
// An accepted add or a requeued tick then walks the queue from the tail, one entry per cycle
// through the memory port, before the next request is taken; a finishing tick walks none.
// A result held by the receiver holds off the next request, and a tick, until it is taken.
// Reset: the queue is emptied and the output register is invalid; no clearing pass.
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler
// Ready queue scheduler with descending priority order and aging on each
// time slice; top level joining controller and datapath.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic [dps_pkg::ID_W-1:0]     s_proc_id,
    input  wire logic signed [dps_pkg::PRIO_W-1:0] s_priority_req,
    input  wire logic [dps_pkg::TIME_W-1:0]   s_need_time,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_ran_valid,
    output logic [dps_pkg::ID_W-1:0]          m_ran_id,
    output logic signed [dps_pkg::PRIO_W-1:0] m_ran_priority,
    output logic [dps_pkg::TIME_W-1:0]        m_ran_used,
    output logic                              m_finished,
    output logic                              m_add_rejected,
    output logic                              m_queue_empty
);
    import dps_pkg::*;

    dps_cmd_t    cmd;
    dps_status_t status;

    // request sequencing
    dps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // queue storage and result formation
    dps_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_proc_id      (s_proc_id),
        .s_priority_req (s_priority_req),
        .s_need_time    (s_need_time),
        .m_ran_valid    (m_ran_valid),
        .m_ran_id       (m_ran_id),
        .m_ran_priority (m_ran_priority),
        .m_ran_used     (m_ran_used),
        .m_finished     (m_finished),
        .m_add_rejected (m_add_rejected),
        .m_queue_empty  (m_queue_empty)
    );

endmodule : dynamic_priority_scheduler
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dynamic priority scheduler. Directed and random
// add/tick requests go through a valid/ready driver; every slice report is
// compared with an in-bench model of the priority-ordered ready queue.
// ----------------------------------------------------------------------------
module tb;
    import dps_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int ITEM_TOTAL  = 1400;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_EVERY = 350;
    localparam int HOLD_AT     = 400;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

    typedef struct packed {
        logic                     sync;  // hold until all reports are back
        logic                     mode;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        need;
    } request_t;

    typedef struct packed {
        logic                     ran_valid;
        logic [ID_W-1:0]          ran_id;
        logic signed [PRIO_W-1:0] ran_priority;
        logic [TIME_W-1:0]        ran_used;
        logic                     finished;
        logic                     add_rejected;
        logic                     queue_empty;
    } slice_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_mode = 1'b0;
    logic [ID_W-1:0]          s_proc_id = '0;
    logic signed [PRIO_W-1:0] s_priority_req = '0;
    logic [TIME_W-1:0]        s_need_time = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_ran_valid;
    logic [ID_W-1:0]          m_ran_id;
    logic signed [PRIO_W-1:0] m_ran_priority;
    logic [TIME_W-1:0]        m_ran_used;
    logic                     m_finished;
    logic                     m_add_rejected;
    logic                     m_queue_empty;

    // stimulus and model state
    request_t      requests_todo[$];
    slice_report_t slice_reports_due[$];
    entry_t        ready_list[$];   // model queue, advanced on accept
    entry_t        plan_list[$];    // model queue used while building stimulus
    logic          drain_first = 1'b0;
    logic          calm_phase = 1'b0;
    request_t      cur_req = '0;
    int            send_gap = 0;
    int            accepted_cnt = 0;
    int            request_total = 0;
    int            reports_seen = 0;
    int            mismatch_cnt = 0;
    int            stall_left = 0;
    int            hold_left = 0;

    dynamic_priority_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_proc_id     (s_proc_id),
        .s_priority_req(s_priority_req),
        .s_need_time   (s_need_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ran_valid   (m_ran_valid),
        .m_ran_id      (m_ran_id),
        .m_ran_priority(m_ran_priority),
        .m_ran_used    (m_ran_used),
        .m_finished    (m_finished),
        .m_add_rejected(m_add_rejected),
        .m_queue_empty (m_queue_empty)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // place behind every entry of equal or higher priority
    function automatic void ready_insert(ref entry_t rq[$], input entry_t ent);
        int pos;
        pos = 0;
        while (pos < rq.size() && $signed(rq[pos].prio) >= $signed(ent.prio))
            pos++;
        rq.insert(pos, ent);
    endfunction

    // one scheduler step: add a process or run the head for one slice
    function automatic slice_report_t schedule_step(ref entry_t rq[$], input request_t r);
        slice_report_t rep;
        entry_t        ent;
        rep = '0;
        if (r.mode == MODE_ADD) begin
            if (rq.size() >= QUEUE_DEPTH || r.need == '0) begin
                rep.add_rejected = 1'b1;
            end else begin
                ent.id   = r.id;
                ent.prio = r.prio;
                ent.need = r.need;
                ent.used = '0;
                ready_insert(rq, ent);
            end
        end else if (rq.size() != 0) begin
            ent = rq.pop_front();
            ent.used = ent.used + 1'b1;
            rep.ran_valid    = 1'b1;
            rep.ran_id       = ent.id;
            rep.ran_priority = ent.prio;
            rep.ran_used     = ent.used;
            if (ent.used == ent.need) begin
                rep.finished = 1'b1;
            end else begin
                // aging, saturating at the lowest priority
                if (ent.prio != PRIO_MIN)
                    ent.prio = ent.prio - 1'b1;
                ready_insert(rq, ent);
            end
        end
        rep.queue_empty = (rq.size() == 0);
        return rep;
    endfunction

    function automatic void plan_request(input logic mode, input logic [ID_W-1:0] id,
                                         input logic signed [PRIO_W-1:0] prio,
                                         input logic [TIME_W-1:0] need);
        request_t r;
        r = {drain_first, mode, id, prio, need};
        drain_first = 1'b0;
        requests_todo.push_back(r);
        void'(schedule_step(plan_list, r));
    endfunction

    // priorities: many ties near zero, some extremes, the rest anywhere
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        v = $urandom_range(0, 4) - 2;
        if (sel < 4)
            return PRIO_W'(v);
        else if (sel == 4)
            return ($urandom_range(0, 1) != 0) ? PRIO_MAX : PRIO_MIN;
        else if (sel == 5)
            return PRIO_MIN + PRIO_W'($urandom_range(0, 2));
        return PRIO_W'($urandom);
    endfunction

    function automatic void plan_random_add();
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] need;
        if ($urandom_range(0, 3) == 0)
            id = ID_W'($urandom_range(0, 3));
        else
            id = ID_W'($urandom);
        // long jobs only when the queue is full, so they never clog it
        if (plan_list.size() == QUEUE_DEPTH && $urandom_range(0, 1) != 0)
            need = TIME_W'($urandom);
        else if ($urandom_range(0, 9) == 0)
            need = '0;
        else
            need = TIME_W'($urandom_range(1, 4));
        plan_request(MODE_ADD, id, pick_prio(), need);
    endfunction

    function automatic void plan_random_tick();
        plan_request(MODE_TICK, ID_W'($urandom), PRIO_W'($urandom), TIME_W'($urandom));
    endfunction

    // request driver
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                slice_reports_due.push_back(schedule_step(ready_list, cur_req));
                accepted_cnt++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (requests_todo.size() != 0) begin
                    if (requests_todo[0].sync && slice_reports_due.size() != 0) begin
                        offer = 1'b0;
                    end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(0, 9);
                    end else begin
                        cur_req = requests_todo.pop_front();
                        offer = 1'b1;
                    end
                end
            end
            s_valid        <= offer;
            s_mode         <= cur_req.mode;
            s_proc_id      <= cur_req.id;
            s_priority_req <= cur_req.prio;
            s_need_time    <= cur_req.need;
            calm_phase     <= (requests_todo.size() < CALM_TAIL);
        end
    end

    // report monitor and checker
    always @(posedge aclk) begin
        slice_report_t got;
        slice_report_t want;
        logic          take;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_ran_valid, m_ran_id, m_ran_priority, m_ran_used,
                       m_finished, m_add_rejected, m_queue_empty};
                if (slice_reports_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("report %0d arrived with no request waiting", reports_seen);
                end else begin
                    want = slice_reports_due.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("report %0d mismatch: ran_valid %b/%b ran_id %h/%h",
                                     reports_seen, want.ran_valid, got.ran_valid,
                                     want.ran_id, got.ran_id);
                            $display("  ran_priority %0d/%0d ran_used %0d/%0d",
                                     want.ran_priority, got.ran_priority,
                                     want.ran_used, got.ran_used);
                            $display("  finished %b/%b add_rejected %b/%b queue_empty %b/%b",
                                     want.finished, got.finished, want.add_rejected,
                                     got.add_rejected, want.queue_empty, got.queue_empty);
                        end
                    end
                end
                reports_seen++;
                // one long back-pressure stretch so the block fills and stalls
                if (reports_seen == HOLD_AT)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            m_ready <= take;
        end
    end

    // run time limit
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int next_drain_at;
        int k;

        // directed: empty tick, zero need, extremes, ties, duplicates, full queue
        plan_request(MODE_TICK, 8'hFF, -16'sd1, 16'hFFFF);
        plan_request(MODE_ADD, 8'h55, PRIO_MAX, 16'h0000);
        plan_request(MODE_ADD, 8'hFF, PRIO_MAX, 16'd1);
        plan_request(MODE_ADD, 8'h00, PRIO_MIN, 16'd2);
        plan_request(MODE_ADD, 8'hAA, 16'sd0, 16'd3);
        plan_request(MODE_ADD, 8'h55, 16'sd0, 16'd1);
        plan_request(MODE_ADD, 8'hAA, 16'sd0, 16'd1);
        for (k = 0; k < 11; k++)
            plan_request(MODE_ADD, ID_W'(k * 23 + 1), PRIO_W'(k - 5), TIME_W'(k % 4 + 1));
        plan_request(MODE_ADD, 8'h5A, 16'sh5555, 16'hFFFF);
        plan_request(MODE_ADD, 8'hA5, 16'shAAAA, 16'hAAAA);
        repeat (5) plan_random_tick();

        // random: fill bursts, full drains, mixed traffic and noise
        next_drain_at = 0;
        while (requests_todo.size() < ITEM_TOTAL) begin
            if (requests_todo.size() >= next_drain_at) begin
                drain_first = 1'b1;
                next_drain_at += DRAIN_EVERY;
            end
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(3, 20)) plan_random_add();
                end
                1: begin
                    while (plan_list.size() != 0)
                        plan_random_tick();
                    repeat ($urandom_range(0, 2)) plan_random_tick();
                end
                2: begin
                    repeat ($urandom_range(5, 30)) begin
                        if ($urandom_range(0, 1) != 0)
                            plan_random_add();
                        else
                            plan_random_tick();
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) != 0)
                            plan_request(MODE_ADD, ID_W'($urandom), PRIO_W'($urandom), '0);
                        else
                            plan_random_add();
                    end
                end
            endcase
        end
        request_total = requests_todo.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < request_total || slice_reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_cnt == 0 && slice_reports_due.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/dps_pkg.sv
design/dps_ctrl.sv
design/dps_datapath.sv
design/dynamic_priority_scheduler.sv
tb/tb.sv
